>>> src/plgs_pkg.sv
`default_nettype none

package plgs_pkg;

    localparam int DEF_MAX_POINTS  = 16;
    localparam int DEF_COLUMNS     = 5;
    localparam int DEF_VALUE_WIDTH = 32;

    // fixed field widths of the ports
    localparam int DATA_W  = 32;
    localparam int PTS_W   = 5;
    localparam int OP_W    = 2;
    localparam int INDEX_W = 4;
    localparam int COL_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_WR_X  = 2'd0,
        OP_WR_Y  = 2'd1,
        OP_EVAL  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // transaction taken this cycle
        logic scan;      // walk breakpoint store
        logic pick;      // choose rows / flag unsorted table
        logic y_next;    // advance value address by one row
        logic cap_y0;    // hold left value
        logic take_y;    // result is the value just read
        logic setup;     // prepare operands of the multiply-divide
        logic div_step;  // one bit of the multiply-divide
        logic fin;       // apply quotient to left value
        logic out_load;  // move result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic eval_ok;   // item is an evaluate with a legal column
        logic scan_done; // last breakpoint in use checked
        logic bad;       // breakpoints in use not sorted
        logic direct;    // answer is a stored value, no interpolation
        logic div_last;  // final multiply-divide step this cycle
        logic out_free;  // output register can take a result
    } t_stat;

endpackage

`default_nettype wire

>>> src/plgs_ctrl.sv
`default_nettype none

module plgs_ctrl
    import plgs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_RD0,
        S_RD1,
        S_SETUP,
        S_DIV,
        S_FIN,
        S_TAKE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.eval_ok ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = i_stat.bad ? S_DONE : S_RD0;
            end
            S_RD0: begin
                // value read in flight; interpolation needs the next row too
                o_cmd.y_next = !i_stat.direct;
                n_state      = i_stat.direct ? S_TAKE : S_RD1;
            end
            S_RD1: begin
                o_cmd.cap_y0 = 1'b1;
                n_state      = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_TAKE: begin
                o_cmd.take_y = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> src/plgs_dpath.sv
`default_nettype none

module plgs_dpath
    import plgs_pkg::*;
#(
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int COLUMNS     = DEF_COLUMNS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_stat                         o_stat,
    input  wire logic [OP_W-1:0]          i_operation,
    input  wire logic [INDEX_W-1:0]       i_point_index,
    input  wire logic [COL_W-1:0]         i_column,
    input  wire logic signed [DATA_W-1:0] i_data_value,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [PTS_W-1:0]         i_cfg_wr_data,
    input  wire logic                     i_stall,
    output logic                          o_valid,
    output logic signed [DATA_W-1:0]      o_result_value,
    output logic                          o_status
);

    localparam int VW        = VALUE_WIDTH;
    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int YA_W      = $clog2(MAX_POINTS * COLUMNS);
    localparam int DIV_STEPS = VALUE_WIDTH + 1;
    localparam int DC_W      = $clog2(DIV_STEPS);
    localparam int PC_W      = (CNT_W > PTS_W) ? CNT_W : PTS_W;

    // stores
    logic signed [VW-1:0] mem_x [MAX_POINTS];
    logic signed [VW-1:0] mem_y [MAX_POINTS*COLUMNS];

    // configuration
    logic [PTS_W-1:0] r_points;

    // latched transaction
    logic signed [VW-1:0] r_q;
    logic [COL_W-1:0]     r_col;
    logic [CNT_W-1:0]     r_n;

    // scan
    logic [CNT_W-1:0]     r_ri;
    logic [IDX_W-1:0]     r_pi;
    logic                 r_pv;
    logic signed [VW-1:0] r_xq;
    logic signed [VW-1:0] r_prev;
    logic                 r_found;
    logic                 r_bad;
    logic [IDX_W-1:0]     r_k;
    logic signed [VW-1:0] r_x0;
    logic signed [VW-1:0] r_x1;

    // value reads
    logic [YA_W-1:0]      r_yaddr;
    logic signed [VW-1:0] r_yq;
    logic signed [VW-1:0] r_y0;

    // multiply-divide
    logic [VW:0]          r_a;
    logic [VW-1:0]        r_b;
    logic [VW-1:0]        r_d;
    logic [VW-1:0]        r_r;
    logic [VW:0]          r_qt;
    logic                 r_neg;
    logic [DC_W-1:0]      r_dcnt;

    // result
    logic signed [VW-1:0]     r_res;
    logic                     r_stat;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_status;

    logic signed [VW-1:0] v_in;
    logic                 idx_ok;
    logic                 col_ok;
    logic [YA_W-1:0]      wr_yaddr;
    logic [PC_W-1:0]      pts_ext;
    logic [CNT_W-1:0]     n_eff;
    logic                 hit;
    logic                 direct;
    logic [IDX_W-1:0]     row_sel;
    logic signed [VW:0]   dy;
    logic [VW:0]          dx_b;
    logic [VW:0]          dx_d;
    logic [VW+1:0]        n_rp;
    logic [VW+1:0]        d1;
    logic [VW+1:0]        d2;
    logic [VW+1:0]        n_rem;
    logic [1:0]           n_c;
    logic signed [VW:0]   n_sum;

    assign v_in     = VW'(i_data_value);
    assign idx_ok   = (32'(i_point_index) < 32'(MAX_POINTS));
    assign col_ok   = (32'(i_column) < 32'(COLUMNS));
    assign wr_yaddr = YA_W'(i_point_index) * YA_W'(COLUMNS) + YA_W'(i_column);

    // a register value of zero acts as one, above the store size it saturates
    assign pts_ext = PC_W'(r_points);
    assign n_eff   = (r_points == '0) ? CNT_W'(1)
                   : (pts_ext > PC_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                   : CNT_W'(pts_ext);

    assign hit    = r_pv && !r_found && (r_xq >= r_q);
    // below the first point, on a point, or past the last point
    assign direct = !r_found || (r_k == '0) || (r_x1 == r_q);
    assign row_sel = !r_found ? IDX_W'(r_n - CNT_W'(1))
                   : (direct ? r_k : r_k - IDX_W'(1));

    assign o_stat.eval_ok   = (t_op'(i_operation) == OP_EVAL) && col_ok;
    assign o_stat.scan_done = r_pv && (CNT_W'(r_pi) == r_n - CNT_W'(1));
    assign o_stat.bad       = r_bad;
    assign o_stat.direct    = direct;
    assign o_stat.div_last  = (r_dcnt == DC_W'(DIV_STEPS - 1));
    assign o_stat.out_free  = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= PTS_W'(1);
        end else if (i_cfg_wr_en) begin
            r_points <= i_cfg_wr_data;
        end
    end

    // stores: written on the accept edge, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (t_op'(i_operation) == OP_WR_X) && idx_ok) begin
            mem_x[IDX_W'(i_point_index)] <= v_in;
        end
        r_xq <= mem_x[r_ri[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (t_op'(i_operation) == OP_WR_Y) && idx_ok && col_ok) begin
            mem_y[wr_yaddr] <= v_in;
        end
        r_yq <= mem_y[r_yaddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_q   <= v_in;
            r_col <= i_column;
            r_n   <= n_eff;
        end
    end

    // breakpoint scan: order check and first point not below the query
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ri    <= '0;
            r_pv    <= 1'b0;
            r_found <= 1'b0;
            r_bad   <= 1'b0;
        end else if (i_cmd.accept) begin
            r_ri    <= '0;
            r_pv    <= 1'b0;
            r_found <= 1'b0;
            r_bad   <= 1'b0;
        end else if (i_cmd.scan) begin
            r_pv <= (r_ri < r_n);
            if (r_ri < r_n) begin
                r_ri <= r_ri + CNT_W'(1);
            end
            if (r_pv && (r_pi != '0) && (r_xq < r_prev)) begin
                r_bad <= 1'b1;
            end
            if (hit) begin
                r_found <= 1'b1;
            end
        end else begin
            r_pv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pi <= r_ri[IDX_W-1:0];
        if (i_cmd.scan && r_pv) begin
            r_prev <= r_xq;
        end
        if (i_cmd.scan && hit) begin
            r_k  <= r_pi;
            r_x1 <= r_xq;
            r_x0 <= r_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_yaddr <= YA_W'(row_sel) * YA_W'(COLUMNS) + YA_W'(r_col);
        end else if (i_cmd.y_next) begin
            r_yaddr <= r_yaddr + YA_W'(COLUMNS);
        end
        if (i_cmd.cap_y0) begin
            r_y0 <= r_yq;
        end
    end

    // operands: |y1-y0|, x-x0, x1-x0
    assign dy   = {r_yq[VW-1], r_yq} - {r_y0[VW-1], r_y0};
    assign dx_b = {r_q[VW-1], r_q} - {r_x0[VW-1], r_x0};
    assign dx_d = {r_x1[VW-1], r_x1} - {r_x0[VW-1], r_x0};

    // floor(a*b/d), one bit of a per step; remainder stays below d
    always_comb begin
        d1   = {2'b00, r_d};
        d2   = {1'b0, r_d, 1'b0};
        n_rp = {1'b0, r_r, 1'b0} + (r_a[VW] ? {2'b00, r_b} : '0);
        if (n_rp >= d2) begin
            n_rem = n_rp - d2;
            n_c   = 2'd2;
        end else if (n_rp >= d1) begin
            n_rem = n_rp - d1;
            n_c   = 2'd1;
        end else begin
            n_rem = n_rp;
            n_c   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_a    <= dy[VW] ? (VW+1)'(-dy) : (VW+1)'(dy);
            r_neg  <= dy[VW];
            r_b    <= dx_b[VW-1:0];
            r_d    <= dx_d[VW-1:0];
            r_r    <= '0;
            r_qt   <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_a    <= {r_a[VW-1:0], 1'b0};
            r_r    <= n_rem[VW-1:0];
            r_qt   <= {r_qt[VW-1:0], 1'b0} + (VW+1)'(n_c);
            r_dcnt <= r_dcnt + DC_W'(1);
        end
    end

    assign n_sum = r_neg ? ({r_y0[VW-1], r_y0} - signed'(r_qt))
                         : ({r_y0[VW-1], r_y0} + signed'(r_qt));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res  <= '0;
            r_stat <= 1'b0;
        end else if (i_cmd.pick && r_bad) begin
            r_stat <= 1'b1;
        end else if (i_cmd.take_y) begin
            r_res <= r_yq;
        end else if (i_cmd.fin) begin
            r_res <= n_sum[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= DATA_W'(r_res);
            r_out_status <= r_stat;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

endmodule

`default_nettype wire

>>> src/piecewise_linear_gain_schedule_core.sv
`default_nettype none

// Piecewise-linear gain schedule. Breakpoint positions and column values are
// loaded by write transactions; an evaluate transaction returns one column at
// a query point, clamped outside the table, exact on a breakpoint, otherwise
// y0 + (y1-y0)*(x-x0)/(x1-x0) truncated toward zero, all signed Q16.16.
// Every transaction returns one result; status 1 flags breakpoints in use
// that are not non-decreasing. The breakpoint store is scanned one entry per
// cycle and the multiply-divide retires one bit per cycle. A finished result
// waits in the output register while the next transaction is taken. Entries
// must be written before use.
module piecewise_linear_gain_schedule_core
    import plgs_pkg::*;
#(
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int COLUMNS     = DEF_COLUMNS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [OP_W-1:0]          i_operation,
    input  wire logic [INDEX_W-1:0]       i_point_index,
    input  wire logic [COL_W-1:0]         i_column,
    input  wire logic signed [DATA_W-1:0] i_data_value,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [DATA_W-1:0]      o_result_value,
    output logic                          o_status,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [PTS_W-1:0]         i_cfg_wr_data
);

    t_cmd  cmd;
    t_stat stat;

    plgs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    plgs_dpath #(
        .MAX_POINTS  (MAX_POINTS),
        .COLUMNS     (COLUMNS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_operation),
        .i_point_index  (i_point_index),
        .i_column       (i_column),
        .i_data_value   (i_data_value),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;
    import plgs_pkg::*;

    localparam int N_PTS       = DEF_MAX_POINTS;
    localparam int N_COLS      = DEF_COLUMNS;
    localparam int ITEM_TARGET = 950;
    localparam int CYCLE_LIMIT = 800000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 80;
    localparam longint VMAX    = 64'sd2147483647;
    localparam longint VMIN    = -64'sd2147483648;

    typedef struct {
        t_op                     op;
        logic [INDEX_W-1:0]      idx;
        logic [COL_W-1:0]        col;
        logic signed [DATA_W-1:0] data;
    } sched_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     status;
    } sched_result_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic [OP_W-1:0]          i_operation = '0;
    logic [INDEX_W-1:0]       i_point_index = '0;
    logic [COL_W-1:0]         i_column = '0;
    logic signed [DATA_W-1:0] i_data_value = '0;
    logic                     i_stall = 1'b0;
    logic                     i_cfg_wr_en = 1'b0;
    logic [PTS_W-1:0]         i_cfg_wr_data = '0;
    logic                     o_stall;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_result_value;
    logic                     o_status;

    piecewise_linear_gain_schedule_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_point_index  (i_point_index),
        .i_column       (i_column),
        .i_data_value   (i_data_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    // predictor state
    logic signed [DATA_W-1:0] bp_x [N_PTS];
    logic signed [DATA_W-1:0] curve_y [N_PTS][N_COLS];
    logic [PTS_W-1:0]         points_reg = 5'd1;

    sched_item_t   pending_items[$];
    sched_result_t expected_results[$];

    // stimulus-side copy of the breakpoints, used to aim queries
    longint gx [N_PTS];

    int items_queued = 0;
    int results_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int n_interp = 0;
    int n_direct = 0;
    int n_unsorted = 0;
    int n_plain = 0;
    int n_settings = 0;

    bit sender_gaps = 1'b1;
    int stall_pct = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int gap_left = 0;
    int hold_left = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp32(longint v);
        if (v > VMAX)
            return VMAX[DATA_W-1:0];
        if (v < VMIN)
            return VMIN[DATA_W-1:0];
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        if ($urandom_range(0, 1))
            return $urandom;
        return clamp32(longint'($urandom_range(0, 1 << 18)) - (1 << 17));
    endfunction

    // Applies one transaction to the gain table and returns what it answers.
    function automatic sched_result_t schedule_step(sched_item_t it);
        sched_result_t res;
        int n, k;
        bit bad;
        longint x, x0, x1, y0, y1, dy, r;
        logic [63:0] mag, dx, span;
        logic [127:0] prod, quo;
        res.value = '0;
        res.status = 1'b0;
        case (it.op)
            OP_WR_X: begin
                bp_x[it.idx] = it.data;
                n_plain++;
            end
            OP_WR_Y: begin
                if (it.col < N_COLS)
                    curve_y[it.idx][it.col] = it.data;
                n_plain++;
            end
            OP_EVAL: begin
                if (it.col >= N_COLS) begin
                    n_plain++;
                end else begin
                    if (points_reg == 0)
                        n = 1;
                    else if (points_reg > N_PTS)
                        n = N_PTS;
                    else
                        n = int'(points_reg);
                    bad = 1'b0;
                    for (k = 1; k < n; k++)
                        if (bp_x[k] < bp_x[k-1])
                            bad = 1'b1;
                    x = it.data;
                    if (bad) begin
                        res.status = 1'b1;
                        n_unsorted++;
                    end else if (x < bp_x[0]) begin
                        res.value = curve_y[0][it.col];
                        n_direct++;
                    end else if (x > bp_x[n-1]) begin
                        res.value = curve_y[n-1][it.col];
                        n_direct++;
                    end else begin
                        k = 0;
                        while (k < n - 1 && bp_x[k] < x)
                            k++;
                        if (bp_x[k] == x) begin
                            res.value = curve_y[k][it.col];
                            n_direct++;
                        end else begin
                            // strictly between rows k-1 and k
                            x0 = bp_x[k-1];
                            x1 = bp_x[k];
                            y0 = curve_y[k-1][it.col];
                            y1 = curve_y[k][it.col];
                            dy = y1 - y0;
                            mag = (dy < 0) ? -dy : dy;
                            dx = x - x0;
                            span = x1 - x0;
                            prod = {64'd0, mag} * {64'd0, dx};
                            quo = prod / {64'd0, span};
                            r = (dy < 0) ? y0 - longint'(quo[63:0]) : y0 + longint'(quo[63:0]);
                            res.value = r[DATA_W-1:0];
                            n_interp++;
                        end
                    end
                end
            end
            default: n_plain++;
        endcase
        return res;
    endfunction

    // sender
    always @(posedge i_clk) begin : drive_items
        sched_item_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                nxt = '{t_op'(i_operation), i_point_index, i_column, i_data_value};
                expected_results.insert(expected_results.size(), schedule_step(nxt));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    i_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_items.size() != 0) begin
                    nxt = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_operation <= nxt.op;
                    i_point_index <= nxt.idx;
                    i_column <= nxt.col;
                    i_data_value <= nxt.data;
                    gap_left <= sender_gaps ? idle_gap() : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_left <= 0;
        end else if (holds_done != hold_requests) begin
            holds_done <= holds_done + 1;
            hold_left <= LONG_HOLD;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            hold_left <= idle_gap();
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        sched_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual value %h status %0d",
                         $time, o_result_value, o_status);
            end else begin
                want = expected_results.pop_front();
                if (o_result_value !== want.value) begin
                    mismatches++;
                    $display("%0t: result_value mismatch, expected %h actual %h",
                             $time, want.value, o_result_value);
                end
                if (o_status !== want.status) begin
                    mismatches++;
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, o_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d of %0d results seen",
                     $time, cycle_count, results_seen, items_queued);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic enqueue(t_op op, int idx, int col, logic signed [DATA_W-1:0] d);
        sched_item_t it;
        it = '{op, idx[INDEX_W-1:0], col[COL_W-1:0], d};
        pending_items.insert(pending_items.size(), it);
        if (op == OP_WR_X)
            gx[idx] = d;
        items_queued++;
    endtask

    // every transaction answers once, so idle means all results are back
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (results_seen != items_queued);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_points(logic [PTS_W-1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        points_reg <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        n_settings++;
    endtask

    initial begin : stimulus
        int phase_no, cfg_v, n_use, n_load, n_items, i, j, r, k, mode;
        longint lo, stride, qx, span;
        int col;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        stall_pct = 20;

        // one breakpoint in use after reset: clamps, exact hit, ignored items
        enqueue(OP_WR_X, 0, 0, 32'sd0);
        enqueue(OP_WR_Y, 0, 0, 32'h7FFF_FFFF);
        enqueue(OP_WR_Y, 0, 1, 32'h8000_0000);
        enqueue(OP_WR_Y, 0, 2, 32'h0000_0000);
        enqueue(OP_WR_Y, 0, 3, 32'hFFFF_FFFF);
        enqueue(OP_WR_Y, 0, 4, 32'h0001_0000);
        enqueue(OP_WR_Y, 3, 5, 32'h1234_5678);
        enqueue(OP_WR_Y, 15, 7, $urandom);
        enqueue(OP_EVAL, 0, 0, 32'h8000_0000);
        enqueue(OP_EVAL, 15, 1, 32'h7FFF_FFFF);
        enqueue(OP_EVAL, 0, 3, 32'sd0);
        enqueue(OP_EVAL, 0, 5, $urandom);
        enqueue(OP_EVAL, 0, 7, $urandom);
        enqueue(OP_NONE, 15, 7, 32'hFFFF_FFFF);
        wait_idle();
        write_points(5'd0);      // zero acts as one
        enqueue(OP_EVAL, 0, 4, 32'sd5);
        wait_idle();
        write_points(5'd2);
        enqueue(OP_WR_X, 1, 0, -32'sd1);
        enqueue(OP_EVAL, 0, 0, 32'sd0);
        // full-range interpolation both ways
        enqueue(OP_WR_X, 0, 0, 32'h8000_0000);
        enqueue(OP_WR_X, 1, 0, 32'h7FFF_FFFF);
        enqueue(OP_WR_Y, 1, 0, 32'h8000_0000);
        enqueue(OP_WR_Y, 1, 1, 32'h7FFF_FFFF);
        enqueue(OP_EVAL, 0, 0, 32'sd1);
        enqueue(OP_EVAL, 0, 1, 32'h7FFF_FFFE);
        enqueue(OP_EVAL, 0, 0, 32'h8000_0001);

        phase_no = 0;
        while (items_queued < ITEM_TARGET) begin
            wait_idle();
            case (phase_no)
                0: cfg_v = 16;
                1: cfg_v = 31;
                2: cfg_v = 0;
                3: cfg_v = 17;
                4: cfg_v = 1;
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 8)
                        cfg_v = $urandom_range(17, 31);
                    else if (r < 12)
                        cfg_v = 0;
                    else
                        cfg_v = $urandom_range(1, 16);
                end
            endcase
            write_points(cfg_v[PTS_W-1:0]);
            n_use = (cfg_v == 0) ? 1 : (cfg_v > N_PTS) ? N_PTS : cfg_v;

            if (phase_no % 4 == 2) begin
                sender_gaps = 1'b0;
                stall_pct = 0;
            end else begin
                sender_gaps = 1'b1;
                stall_pct = $urandom_range(5, 40);
            end
            if (phase_no == 3) begin
                sender_gaps = 1'b0;
                hold_requests++;   // receiver blocks while the sender keeps offering
            end

            // the first phase fills the whole table so nothing is read unwritten
            if (phase_no == 0 || $urandom_range(0, 99) < 70) begin
                n_load = (phase_no == 0) ? N_PTS : n_use;
                mode = $urandom_range(0, 2);
                case (mode)
                    0: lo = VMIN + $urandom_range(0, 1 << 20);
                    1: lo = longint'(signed'($urandom));
                    default: lo = -longint'(n_load) * 65536 + $urandom_range(0, 1 << 16);
                endcase
                for (i = 0; i < n_load; i++) begin
                    enqueue(OP_WR_X, i, 0, clamp32(lo));
                    case (mode)
                        0: stride = $urandom_range(0, 32'hFFFF_FFFF / n_load);
                        1: stride = $urandom_range(0, 3);   // duplicates and neighbors
                        default: stride = $urandom_range(0, 1 << 17);
                    endcase
                    lo = lo + stride;
                end
            end
            if (phase_no == 0) begin
                for (i = 0; i < N_PTS; i++)
                    for (j = 0; j < N_COLS; j++)
                        enqueue(OP_WR_Y, i, j, rand_value());
            end else begin
                repeat ($urandom_range(0, 2 * n_use))
                    enqueue(OP_WR_Y, $urandom_range(0, n_use - 1), $urandom_range(0, 4),
                            rand_value());
            end

            n_items = $urandom_range(30, 60);
            for (i = 0; i < n_items; i++) begin
                if (phase_no == 5 && i == n_items / 2)
                    wait_idle();
                r = $urandom_range(0, 99);
                if (r >= 88) begin
                    enqueue(t_op'($urandom_range(0, 3)), $urandom_range(0, 15),
                            $urandom_range(0, 7), $urandom);
                end else begin
                    col = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7)
                                                        : $urandom_range(0, 4);
                    k = $urandom_range(0, n_use - 1);
                    r = $urandom_range(0, 99);
                    if (r < 10)
                        qx = gx[0] - $urandom_range(1, 1000);
                    else if (r < 20)
                        qx = gx[n_use-1] + $urandom_range(1, 1000);
                    else if (r < 25)
                        qx = $urandom_range(0, 1) ? VMAX : VMIN;
                    else if (r < 40)
                        qx = gx[k];
                    else if (k < n_use - 1 && gx[k+1] > gx[k]) begin
                        span = gx[k+1] - gx[k];
                        qx = gx[k] + longint'({$urandom, $urandom} % (span + 1));
                    end else
                        qx = gx[k] + longint'($urandom_range(0, 1 << 16)) - (1 << 15);
                    enqueue(OP_EVAL, $urandom_range(0, 15), col, clamp32(qx));
                end
            end
            phase_no++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        $display("%0d transactions over %0d point-count settings: %0d interpolated,",
                 items_queued, n_settings, n_interp);
        $display("  %0d clamped or on a breakpoint, %0d unsorted-table errors, %0d other",
                 n_direct, n_unsorted, n_plain);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
